@@ sv/glbp_pkg.sv @@
package glbp_pkg;

	// line store depth, largest frame width handled
	localparam int MAX_WIDTH = 2048;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WID_W     = $clog2(MAX_WIDTH + 1);

	// frame size registers and row counters
	localparam int DIM_W = 12;
	localparam int ROW_W = DIM_W + 1;
	localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = DIM_W'(640);
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(480);

	// pixel data and gray conversion: floor(s / 3) as (s * 683) >> 11, exact for s < 2048
	localparam int PIX_W      = 8;
	localparam int SUM_W      = PIX_W + 2;
	localparam int PROD_W     = 2 * SUM_W;
	localparam int DIV3_MUL   = 683;
	localparam int DIV3_SHIFT = 11;

	// window and pattern
	localparam int WIN_N = 9;
	localparam int NB_N  = 8;

	// result queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// where the new window column comes from
	typedef enum logic [1:0] {
		COL_PIXEL = 2'd0,
		COL_EDGE  = 2'd1,
		COL_ZERO  = 2'd2
	} col_mode_t;

	typedef struct packed {
		logic             kind;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pix_t;

	typedef struct packed {
		logic [NB_N-1:0]  lbp_code;
		logic [PIX_W-1:0] gray_level;
		logic             end_of_row;
		logic             end_of_frame;
	} lbp_t;

	typedef struct packed {
		logic emit;
		logic left_edge;
		logic end_of_row;
		logic end_of_frame;
	} out_info_t;

	typedef struct packed {
		logic             valid;
		col_mode_t        mode;
		logic [COL_W-1:0] addr;
		logic [PIX_W-1:0] gray;
		logic             top_from_mid;
		out_info_t        info;
	} ls_req_t;

	typedef struct packed {
		logic             valid;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
		out_info_t        info;
	} col_t;

	typedef struct packed {
		logic valid;
		lbp_t data;
	} lbp_push_t;

endpackage

@@ sv/glbp_ctrl.sv @@
module glbp_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  glbp_pkg::cfg_reg_t         cfg_index,
	input  logic [glbp_pkg::DIM_W-1:0] cfg_data,
	input  logic                       pix_accept,
	input  glbp_pkg::pix_t             pix,
	output glbp_pkg::ls_req_t          req
);
	import glbp_pkg::*;

	logic [DIM_W-1:0]  frame_width_q;
	logic [DIM_W-1:0]  frame_height_q;
	logic [COL_W-1:0]  in_column_q;
	logic [ROW_W-1:0]  in_row_q;
	logic [COL_W-1:0]  out_column_q;
	logic [DIM_W-1:0]  out_row_q;

	logic [WID_W-1:0]  eff_w;
	logic [DIM_W-1:0]  eff_h;
	logic              draining;
	logic              step;
	logic              col_wrap;
	logic              emit;
	logic              eor;
	logic              eof;
	col_mode_t         mode;
	logic [SUM_W-1:0]  sum;
	logic [PROD_W-1:0] prod;

	always_comb begin
		if (frame_width_q == '0) begin
			eff_w = WID_W'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			eff_w = WID_W'(MAX_WIDTH);
		end else begin
			eff_w = WID_W'(frame_width_q);
		end
	end

	assign eff_h    = (frame_height_q == '0) ? DIM_W'(1) : frame_height_q;
	assign draining = in_row_q >= ROW_W'(eff_h);
	// drain ticks mid-frame are dropped
	assign step     = pix_accept && (draining || !pix.kind);
	assign col_wrap = (WID_W'(in_column_q) + WID_W'(1)) >= eff_w;
	assign emit     = (in_row_q > ROW_W'(1)) || ((in_row_q == ROW_W'(1)) && (in_column_q != '0));
	assign eor      = (WID_W'(out_column_q) + WID_W'(1)) >= eff_w;
	assign eof      = eor && ((out_row_q + DIM_W'(1)) >= eff_h);

	always_comb begin
		if (!draining) begin
			mode = COL_PIXEL;
		end else if (in_row_q == ROW_W'(eff_h)) begin
			mode = COL_EDGE;
		end else begin
			mode = COL_ZERO;
		end
	end

	assign sum  = SUM_W'(pix.red) + SUM_W'(pix.green) + SUM_W'(pix.blue);
	assign prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);

	always_comb begin
		req.valid             = step;
		req.mode              = mode;
		req.addr              = in_column_q;
		req.gray              = PIX_W'(prod >> DIV3_SHIFT);
		req.top_from_mid      = in_row_q == ROW_W'(1);
		req.info.emit         = emit;
		req.info.left_edge    = out_column_q == '0;
		req.info.end_of_row   = eor;
		req.info.end_of_frame = eof;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_column_q  <= '0;
			in_row_q     <= '0;
			out_column_q <= '0;
			out_row_q    <= '0;
		end else if (step) begin
			if (col_wrap) begin
				in_column_q <= '0;
				in_row_q    <= in_row_q + ROW_W'(1);
			end else begin
				in_column_q <= in_column_q + COL_W'(1);
			end
			if (emit) begin
				if (eor) begin
					out_column_q <= '0;
					out_row_q    <= out_row_q + DIM_W'(1);
				end else begin
					out_column_q <= out_column_q + COL_W'(1);
				end
				if (eof) begin
					in_column_q  <= '0;
					in_row_q     <= '0;
					out_column_q <= '0;
					out_row_q    <= '0;
				end
			end
		end
	end

endmodule

@@ sv/glbp_line_store.sv @@
module glbp_line_store (
	input  logic              clk,
	input  logic              arst_n,
	input  glbp_pkg::ls_req_t req,
	output glbp_pkg::col_t    col
);
	import glbp_pkg::*;

	localparam int WORD_W = 2 * PIX_W;

	// one word per column: {upper row, middle row}
	logic [WORD_W-1:0] mem [MAX_WIDTH];

	logic [WORD_W-1:0] rd_s1;
	logic [WORD_W-1:0] fwd_word_s1;
	ls_req_t           req_s1;
	logic              vld_s1;
	logic              fwd_s1;

	logic [PIX_W-1:0]  up_rd;
	logic [PIX_W-1:0]  mid_rd;
	logic              wr_en;
	logic [WORD_W-1:0] wr_word;

	// same-column back-to-back access (width of one) takes the word being written
	assign up_rd   = fwd_s1 ? fwd_word_s1[WORD_W-1:PIX_W] : rd_s1[WORD_W-1:PIX_W];
	assign mid_rd  = fwd_s1 ? fwd_word_s1[PIX_W-1:0] : rd_s1[PIX_W-1:0];
	assign wr_en   = vld_s1 && (req_s1.mode == COL_PIXEL);
	assign wr_word = {mid_rd, req_s1.gray};

	always_ff @(posedge clk) begin
		if (req.valid) begin
			rd_s1 <= mem[req.addr];
		end
		if (wr_en) begin
			mem[req_s1.addr] <= wr_word;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			req_s1      <= req;
			fwd_word_s1 <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			vld_s1 <= req.valid;
			fwd_s1 <= req.valid && wr_en && (req.addr == req_s1.addr);
		end
	end

	always_comb begin
		col.valid = vld_s1;
		col.info  = req_s1.info;
		col.top   = '0;
		col.mid   = '0;
		col.bot   = '0;
		case (req_s1.mode)
			COL_PIXEL: begin
				col.top = req_s1.top_from_mid ? mid_rd : up_rd;
				col.mid = mid_rd;
				col.bot = req_s1.gray;
			end
			COL_EDGE: begin
				col.top = req_s1.top_from_mid ? mid_rd : up_rd;
				col.mid = mid_rd;
				col.bot = mid_rd;
			end
			default: ;
		endcase
	end

endmodule

@@ sv/glbp_window.sv @@
module glbp_window (
	input  logic                clk,
	input  logic                arst_n,
	input  glbp_pkg::col_t      col,
	output glbp_pkg::lbp_push_t push
);
	import glbp_pkg::*;

	logic [PIX_W-1:0] win_q [WIN_N];
	logic [PIX_W-1:0] win_d [WIN_N];
	logic [PIX_W-1:0] nb    [NB_N];
	logic [NB_N-1:0]  code;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_d[r*3]     = win_q[r*3 + 1];
			win_d[r*3 + 1] = win_q[r*3 + 2];
		end
		win_d[2] = col.top;
		win_d[5] = col.mid;
		win_d[8] = col.bot;
	end

	// edge columns replicate the centre column
	always_comb begin
		nb[0] = col.info.left_edge  ? win_d[1] : win_d[0];
		nb[1] = win_d[1];
		nb[2] = col.info.end_of_row ? win_d[1] : win_d[2];
		nb[3] = col.info.end_of_row ? win_d[4] : win_d[5];
		nb[4] = col.info.end_of_row ? win_d[7] : win_d[8];
		nb[5] = win_d[7];
		nb[6] = col.info.left_edge  ? win_d[7] : win_d[6];
		nb[7] = col.info.left_edge  ? win_d[4] : win_d[3];
		for (int i = 0; i < NB_N; i++) begin
			code[i] = nb[i] >= win_d[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN_N; k++) begin
				win_q[k] <= '0;
			end
		end else if (col.valid) begin
			win_q <= win_d;
		end
	end

	always_comb begin
		push.valid             = col.valid && col.info.emit;
		push.data.lbp_code     = code;
		push.data.gray_level   = win_d[4];
		push.data.end_of_row   = col.info.end_of_row;
		push.data.end_of_frame = col.info.end_of_frame;
	end

endmodule

@@ sv/glbp_out_fifo.sv @@
module glbp_out_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  glbp_pkg::lbp_push_t         push,
	input  logic                        pop,
	output logic [glbp_pkg::QCNT_W-1:0] count,
	output logic                        head_valid,
	output glbp_pkg::lbp_t              head
);
	import glbp_pkg::*;

	lbp_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign count      = count_q;
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push.valid) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

@@ sv/gray_lbp_3x3_stream_top.sv @@
// Gray-level 3x3 local binary pattern over a raster RGB stream. Each pixel request is
// turned into gray = floor((red + green + blue) / 3), and every gray pixel gets an 8-bit
// pattern code, bit 0 the top-left neighbour and then clockwise to bit 7 the left one, a
// bit being set when that neighbour is at least the centre; frame borders replicate the
// nearest edge pixel. One request is taken per clock, without bubbles, as long as the
// consumer keeps up: the two line stores share one 16-bit wide memory with a read port
// and a write port; a request reads its column when taken and the word is written back
// the next cycle, with a one-word forward covering a frame one pixel wide. The result of
// pixel k comes out on the request W + 1 later (W the effective width), through the line
// store read register and the result queue, so after the last pixel of a frame send W + 1
// drain ticks (kind = 1) to flush the final row; drain ticks sent while pixels are still
// expected are dropped, and pixels sent during the flush count as ticks. Results sit in a
// four-entry queue; the input stalls only when that queue plus the request in flight
// already take all four entries. Width 0 acts as 1 and widths above 2048 as 2048;
// height 0 acts as 1. Line store contents are undefined after reset; no clearing pass is
// run, since unwritten entries never reach a result. Frame size registers are written
// through the cfg port, which is always ready, and take effect at once.
module gray_lbp_3x3_stream_top (
	input  logic                       clk,
	input  logic                       arst_n,
	// pixel input
	input  logic                       pix_valid,
	output logic                       pix_stall,
	input  glbp_pkg::pix_t             pix,
	// pattern output
	output logic                       lbp_valid,
	input  logic                       lbp_stall,
	output glbp_pkg::lbp_t             lbp,
	// register writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  glbp_pkg::cfg_reg_t         cfg_index,
	input  logic [glbp_pkg::DIM_W-1:0] cfg_data
);
	import glbp_pkg::*;

	ls_req_t           req;
	col_t              col;
	lbp_push_t         push;
	logic [QCNT_W-1:0] fifo_count;
	logic [QCNT_W:0]   pending;
	logic              pix_accept;
	logic              pop;

	assign cfg_ready = 1'b1;

	// queued results plus the one in the memory stage must leave a slot for a new request
	assign pending    = (QCNT_W + 1)'(fifo_count) + (QCNT_W + 1)'(col.valid);
	assign pix_stall  = pending > (QCNT_W + 1)'(QDEPTH - 1);
	assign pix_accept = pix_valid && !pix_stall;
	assign pop        = lbp_valid && !lbp_stall;

	// counters, frame registers and gray conversion
	glbp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix_accept (pix_accept),
		.pix        (pix),
		.req        (req)
	);

	// line store read-modify-write, yields the new right column of the window
	glbp_line_store u_line_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.col    (col)
	);

	// 3x3 window and neighbour compare
	glbp_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.col    (col),
		.push   (push)
	);

	// result queue decoupling the consumer
	glbp_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.count      (fifo_count),
		.head_valid (lbp_valid),
		.head       (lbp)
	);

`ifndef SYNTHESIS
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (fifo_count != QCNT_W'(QDEPTH)))
		else $error("result queue overflow");

	a_eof_needs_eor: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && push.data.end_of_frame) |-> push.data.end_of_row)
		else $error("end of frame flagged off the end of a row");

	a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (fifo_count != '0))
		else $error("input stalled with no queued result");
`endif

endmodule

@@ test/gray_lbp_3x3_stream_top_test.sv @@
`timescale 1ns / 100ps

module gray_lbp_3x3_stream_top_test;
	import glbp_pkg::*;

	// request kinds on the pixel channel
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// quiet cycles let after the last result before a register write or the end;
	// covers the pipeline stages and the result queue with margin
	localparam int SETTLE_CYCLES = 16;
	// watchdog: cycles in a row with no request moving on any channel
	localparam int QUIET_LIMIT   = 2000;
	// requests taken by the random frames before the stimulus stops
	localparam int RANDOM_ITEMS  = 350;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             pix_valid = 1'b0;
	logic             pix_stall;
	pix_t             pix       = '0;
	logic             lbp_valid;
	logic             lbp_stall = 1'b0;
	lbp_t             lbp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	cfg_reg_t         cfg_index = REG_FRAME_WIDTH;
	logic [DIM_W-1:0] cfg_data  = '0;

	gray_lbp_3x3_stream_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix      (pix),
		.lbp_valid(lbp_valid),
		.lbp_stall(lbp_stall),
		.lbp      (lbp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// idle and stall odds in percent, changed per test phase
	int idle_pct;
	int stall_pct;

	int errors          = 0;
	int results_checked = 0;
	int items_sent;
	int items_taken;
	int frames_done;
	int quiet_cycles    = 0;
	int unsigned widest;
	int unsigned tallest;

	// ------------------------------------------------------------------
	// Pattern predictor: own copy of the frame registers, line stores,
	// 3x3 window and the input/output raster positions.
	// ------------------------------------------------------------------
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	logic [PIX_W-1:0] upper_row  [MAX_WIDTH];
	logic [PIX_W-1:0] middle_row [MAX_WIDTH];
	logic [PIX_W-1:0] win3       [WIN_N];
	int unsigned      src_col;
	int unsigned      src_row;
	int unsigned      dst_col;
	int unsigned      dst_row;

	// expected results, oldest first
	lbp_t pending_patterns [$];
	lbp_t head_pattern;

	function automatic void clear_model();
		width_reg  = FRAME_WIDTH_RESET;
		height_reg = FRAME_HEIGHT_RESET;
		// the stores are undefined after reset; unwritten entries never reach a result
		for (int i = 0; i < MAX_WIDTH; i++) begin
			upper_row[i]  = '0;
			middle_row[i] = '0;
		end
		for (int i = 0; i < WIN_N; i++)
			win3[i] = '0;
		src_col = 0;
		src_row = 0;
		dst_col = 0;
		dst_row = 0;
	endfunction

	// width 0 acts as 1, anything past the store depth is clipped
	function automatic int unsigned active_width();
		int unsigned w;
		w = width_reg;
		if (w == 0)
			w = 1;
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned active_height();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	// Advance the predictor by one taken request; queue the result it causes, if any.
	function automatic void compute_pattern(input pix_t p);
		int unsigned      w, h, c, lc, rc;
		int               r, i;
		bit               draining, emit, eor, eof;
		logic [PIX_W-1:0] top, mid, bot, ctr;
		logic [SUM_W-1:0] sum;
		logic [PIX_W-1:0] nb [NB_N];
		lbp_t             res;
		w = active_width();
		h = active_height();
		draining = src_row >= h;
		top = '0;
		mid = '0;
		bot = '0;
		// tick inside a frame: dropped
		if (!draining && p.kind == KIND_TICK)
			return;
		items_taken++;
		c = (src_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : src_col;
		if (!draining) begin
			sum = SUM_W'(p.red) + SUM_W'(p.green) + SUM_W'(p.blue);
			top = (src_row == 1) ? middle_row[c] : upper_row[c];
			mid = middle_row[c];
			bot = PIX_W'(sum / 3);
			upper_row[c]  = middle_row[c];
			middle_row[c] = bot;
		end else if (src_row == h) begin
			// first flush row: bottom edge replicates the last real row
			top = (src_row == 1) ? middle_row[c] : upper_row[c];
			mid = middle_row[c];
			bot = mid;
		end
		for (r = 0; r < 3; r++) begin
			win3[r * 3]     = win3[r * 3 + 1];
			win3[r * 3 + 1] = win3[r * 3 + 2];
		end
		win3[2] = top;
		win3[5] = mid;
		win3[8] = bot;

		emit = (src_row > 1) || (src_row == 1 && src_col >= 1);
		if (src_col + 1 >= w) begin
			src_col = 0;
			src_row++;
		end else begin
			src_col++;
		end
		if (!emit)
			return;

		// left/right edges replicate the centre column
		lc  = (dst_col == 0) ? 1 : 0;
		rc  = (dst_col + 1 >= w) ? 1 : 2;
		ctr = win3[4];
		nb[0] = win3[lc];
		nb[1] = win3[1];
		nb[2] = win3[rc];
		nb[3] = win3[3 + rc];
		nb[4] = win3[6 + rc];
		nb[5] = win3[7];
		nb[6] = win3[6 + lc];
		nb[7] = win3[3 + lc];
		for (i = 0; i < NB_N; i++)
			res.lbp_code[i] = (nb[i] >= ctr);
		eor = dst_col + 1 >= w;
		eof = eor && (dst_row + 1 >= h);
		res.gray_level   = ctr;
		res.end_of_row   = eor;
		res.end_of_frame = eof;
		pending_patterns.push_back(res);

		if (eor) begin
			dst_col = 0;
			dst_row++;
		end else begin
			dst_col++;
		end
		if (eof) begin
			src_col = 0;
			src_row = 0;
			dst_col = 0;
			dst_row = 0;
			frames_done++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Result side: check each taken result against the oldest expectation,
	// then pick the stall for the next cycle.
	// ------------------------------------------------------------------
	function automatic void compare_field(input string name, input logic [PIX_W-1:0] want,
			input logic [PIX_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (lbp_valid === 1'b1 && lbp_stall === 1'b0) begin
			if (pending_patterns.size() == 0) begin
				$error("result with nothing expected: lbp_code %0d, gray_level %0d",
					lbp.lbp_code, lbp.gray_level);
				errors++;
			end else begin
				head_pattern = pending_patterns.pop_front();
				compare_field("lbp_code", head_pattern.lbp_code, lbp.lbp_code);
				compare_field("gray_level", head_pattern.gray_level, lbp.gray_level);
				compare_field("end_of_row", PIX_W'(head_pattern.end_of_row),
					PIX_W'(lbp.end_of_row));
				compare_field("end_of_frame", PIX_W'(head_pattern.end_of_frame),
					PIX_W'(lbp.end_of_frame));
				results_checked++;
			end
		end
		lbp_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// watchdog: ends the run when no channel moves for too long
	always @(posedge clk) begin
		if ((pix_valid === 1'b1 && pix_stall === 1'b0) ||
				(lbp_valid === 1'b1 && lbp_stall === 1'b0) ||
				(cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("no request moved for %0d cycles, %0d results still expected",
				QUIET_LIMIT, pending_patterns.size());
			$display("gray_lbp_3x3_stream_top_test NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers. All tasks are entered just after a rising edge.
	// ------------------------------------------------------------------
	function automatic void set_idling(input int phase);
		case (phase % 4)
			0: begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct  = 46;
				stall_pct = 0;
			end
			2: begin
				idle_pct  = 0;
				stall_pct = 46;
			end
			default: begin
				idle_pct  = 12;
				stall_pct = 12;
			end
		endcase
	endfunction

	// One pixel request; random idle gap first, then held until taken.
	// Valid is only lowered on a gap, so it never drops and rises in one step.
	task automatic send_request(input pix_t p);
		if ($urandom_range(0, 99) < idle_pct) begin
			pix_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct);
		end
		pix       <= p;
		pix_valid <= 1'b1;
		@(posedge clk);
		while (pix_stall !== 1'b0)
			@(posedge clk);
		compute_pattern(p);
		items_sent++;
	endtask

	// Stop sending, let every expected result come out, then let the pipeline settle.
	task automatic wait_drained();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending_patterns.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Register write, only ever issued with the block idle.
	task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] value);
		wait_drained();
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		if (idx == REG_FRAME_WIDTH)
			width_reg = value;
		else
			height_reg = value;
		if (active_width() > widest)
			widest = active_width();
		if (active_height() > tallest)
			tallest = active_height();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
	endtask

	// Random colour; a quarter are flat grays so equal neighbours show up often.
	function automatic pix_t random_pixel();
		pix_t p;
		p.kind  = KIND_PIXEL;
		p.red   = PIX_W'($urandom);
		p.green = PIX_W'($urandom);
		p.blue  = PIX_W'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			p.red   = PIX_W'($urandom_range(0, 3) * 85);
			p.green = p.red;
			p.blue  = p.red;
		end
		return p;
	endfunction

	function automatic pix_t make_tick();
		pix_t p;
		p.kind  = KIND_TICK;
		p.red   = PIX_W'($urandom);
		p.green = PIX_W'($urandom);
		p.blue  = PIX_W'($urandom);
		return p;
	endfunction

	// Run the current frame to its end-of-frame result. While rows are still due,
	// tick_pct of the requests are stray ticks; during the flush, drain_pix_pct
	// of them are pixels standing in for ticks.
	task automatic feed_frame(input int tick_pct, input int drain_pix_pct);
		int start;
		start = frames_done;
		while (frames_done == start) begin
			if (src_row < active_height())
				send_request(($urandom_range(0, 99) < tick_pct) ? make_tick() : random_pixel());
			else
				send_request(($urandom_range(0, 99) < drain_pix_pct) ?
					random_pixel() : make_tick());
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset sizes: the first row wraps at 640 pixels, seen as the first result two
	// pixels into the second row; then the frame is cut to 8 x 2 mid-frame and flushed.
	task automatic test_reset_geometry();
		set_idling(3);
		repeat (FRAME_WIDTH_RESET + 2)
			send_request(random_pixel());
		set_frame(8, 2);
		feed_frame(0, 0);
	endtask

	// 3x3 frame of extreme colours, a stray tick inside the frame and a pixel
	// inside the flush.
	task automatic test_pixel_extremes();
		pix_t seq [9];
		seq = '{
			'{KIND_PIXEL, 8'd0,   8'd0,   8'd0},
			'{KIND_PIXEL, 8'd255, 8'd255, 8'd255},
			'{KIND_PIXEL, 8'd255, 8'd0,   8'd0},
			'{KIND_PIXEL, 8'd0,   8'd255, 8'd0},
			'{KIND_PIXEL, 8'd0,   8'd0,   8'd255},
			'{KIND_PIXEL, 8'd255, 8'd255, 8'd254},
			'{KIND_PIXEL, 8'd1,   8'd1,   8'd1},
			'{KIND_PIXEL, 8'd128, 8'd127, 8'd128},
			'{KIND_PIXEL, 8'd170, 8'd85,  8'd255}
		};
		set_idling(0);
		set_frame(3, 3);
		for (int i = 0; i < 9; i++) begin
			send_request(seq[i]);
			if (i == 3)
				send_request(make_tick());
		end
		send_request(random_pixel());
		feed_frame(0, 0);
	endtask

	// Degenerate shapes: zero registers, one column, one row, tiny squares,
	// and a flat frame where every neighbour equals the centre.
	task automatic test_small_sizes();
		set_idling(1);
		set_frame(0, 0);
		feed_frame(10, 30);
		set_frame(1, 1);
		feed_frame(10, 30);
		set_idling(2);
		set_frame(1, 4);
		feed_frame(10, 30);
		set_frame(5, 1);
		feed_frame(10, 30);
		set_idling(3);
		set_frame(2, 2);
		feed_frame(10, 30);
		set_frame(3, 2);
		for (int i = 0; i < 6; i++)
			send_request('{KIND_PIXEL, 8'd90, 8'd60, 8'd30});
		feed_frame(0, 0);
	endtask

	// Size changes in the middle of a frame: narrower and taller, then a height
	// below the rows already taken so the flush starts past the last row.
	task automatic test_mid_frame_resize();
		set_idling(2);
		set_frame(5, 4);
		repeat (12)
			send_request(random_pixel());
		set_frame(3, 6);
		feed_frame(0, 0);
		set_idling(1);
		set_frame(6, 6);
		repeat (20)
			send_request(random_pixel());
		write_reg(REG_FRAME_HEIGHT, 2);
		feed_frame(0, 0);
	endtask

	// Largest shapes: width register all ones (clipped to the store depth) and
	// height register all ones, each cut down partway through its frame; then a
	// 200-pixel row and a 200-row column.
	task automatic test_large_sizes();
		set_idling(1);
		set_frame(12'hFFF, 2);
		repeat (20)
			send_request(random_pixel());
		write_reg(REG_FRAME_WIDTH, 5);
		feed_frame(0, 0);
		set_frame(1, 12'hFFF);
		repeat (10)
			send_request(random_pixel());
		write_reg(REG_FRAME_HEIGHT, 3);
		feed_frame(0, 0);
		set_idling(3);
		set_frame(200, 1);
		feed_frame(0, 0);
		set_frame(1, 200);
		feed_frame(0, 0);
	endtask

	// Random frames of mostly small shapes, idle mix changing every frame;
	// one in ten is resized partway through.
	task automatic test_random_frames();
		int start;
		int phase;
		int w, h;
		start = items_taken;
		phase = 0;
		while (items_taken - start < RANDOM_ITEMS) begin
			set_idling(phase);
			phase++;
			case ($urandom_range(0, 19))
				0: begin
					w = $urandom_range(41, 160);
					h = $urandom_range(1, 3);
				end
				1, 2, 3, 4, 5: begin
					w = $urandom_range(9, 40);
					h = $urandom_range(0, 6);
				end
				default: begin
					w = $urandom_range(0, 8);
					h = $urandom_range(0, 10);
				end
			endcase
			set_frame(DIM_W'(w), DIM_W'(h));
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, active_width() * active_height()))
					send_request(random_pixel());
				set_frame(DIM_W'($urandom_range(0, 12)), DIM_W'($urandom_range(0, 8)));
			end
			feed_frame(5, 20);
		end
	endtask

	initial begin
		items_sent      = 0;
		items_taken     = 0;
		frames_done     = 0;
		widest          = 0;
		tallest         = 0;
		clear_model();
		set_idling(0);
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_pixel_extremes();
		test_small_sizes();
		test_mid_frame_resize();
		test_large_sizes();
		test_random_frames();
		wait_drained();

		$display("%0d pixel/tick requests over %0d frames, widths 1..%0d, heights 1..%0d,",
			items_sent, frames_done, widest, tallest);
		$display("under four idle/stall mixes; %0d results checked, %0d mismatches",
			results_checked, errors);
		if (errors == 0)
			$display("gray_lbp_3x3_stream_top_test OK");
		else
			$display("gray_lbp_3x3_stream_top_test NOT OK");
		$finish;
	end

endmodule
